>>> design/qes_pkg.sv
// qes_pkg: shared types and constants for the quadratic equation solver
// no dependencies

package qes_pkg;

    localparam int unsigned CfgAddrWidth = 3;

    typedef enum logic [CfgAddrWidth-1:0] {
        REG_COEF_ZERO_LIMIT = 3'd0,
        REG_DISC_ZERO_LIMIT = 3'd4
    } t_reg_addr;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_INFINITE = 2'd1,
        KIND_ONE      = 2'd2,
        KIND_TWO      = 2'd3
    } t_root_kind;

endpackage

>>> design/qes_if.sv
// qes_if: valid/ready channel carrying a payload of type T
// no dependencies

interface qes_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/quadratic_equation_solver.sv
// quadratic_equation_solver: top level, classifies roots of a*x^2+b*x+c=0
// depends on qes_pkg, qes_if, qes_sqrt_cell, qes_div_cell
//
// channel  | dir | handshake          | payload
// in       | in  | valid/ready        | coef_a, coef_b, coef_c
// out      | out | valid/ready        | root_kind, root_first, root_second, overflow
// cfg      | in  | apb psel/penable   | coef_zero_limit @0, disc_zero_limit @4
//
// one item per cycle unless the output stalls. the pipe holds the square root chain
// (one cell per root bit, W + 2 bits, W = COEF_WIDTH) and the divider chain (one cell
// per quotient bit). the whole pipe advances when the output register is empty or
// taken, so a stall at the output holds every stage.
// reset clears the valid bits and reloads both limit registers.

module quadratic_equation_solver
    import qes_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    qes_if.sink                     in_ch,
    qes_if.source                   out_ch,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int W   = COEF_WIDTH;
    localparam int MW  = W;              // magnitude width
    localparam int DWD = 2 * W + 3;      // discriminant magnitude width
    localparam int RW  = W + 2;          // sqrt result width
    localparam int NW  = W + 2 + FRAC_BITS; // numerator after shift
    localparam int DV  = W + 2;          // divisor width
    localparam int QW  = NW;

    // ---- configuration
    logic [15:0] r_czl;
    logic [31:0] r_dzl;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_czl <= 16'd1;
            r_dzl <= 32'd4295;
        end else if (psel && penable && pwrite) begin
            if (paddr == REG_COEF_ZERO_LIMIT) r_czl <= pwdata[15:0];
            if (paddr == REG_DISC_ZERO_LIMIT) r_dzl <= pwdata;
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == REG_COEF_ZERO_LIMIT) prdata = {16'd0, r_czl};
        if (paddr == REG_DISC_ZERO_LIMIT) prdata = r_dzl;
    end

    function automatic logic is_small(input logic [MW-1:0] m, input logic [15:0] lim);
        is_small = (m == '0) || (MW+16)'(m) < (MW+16)'(lim);
    endfunction

    // ---- pipeline enable
    logic w_adv;
    logic r_out_v;
    assign w_adv    = !r_out_v || out_ch.ready;
    assign in_ch.ready = w_adv;
    logic w_in_fire;
    assign w_in_fire = in_ch.valid && w_adv;

    // ---- stage 1: magnitudes, classification, products
    logic signed [W-1:0] w_a, w_b, w_c;
    assign w_a = in_ch.data.coef_a;
    assign w_b = in_ch.data.coef_b;
    assign w_c = in_ch.data.coef_c;

    logic [MW-1:0] w_ma, w_mb, w_mc;
    assign w_ma = w_a[W-1] ? MW'(-w_a) : MW'(w_a);
    assign w_mb = w_b[W-1] ? MW'(-w_b) : MW'(w_b);
    assign w_mc = w_c[W-1] ? MW'(-w_c) : MW'(w_c);

    logic               r1_v;
    logic [2*MW-1:0]    r1_p, r1_q;
    logic               r1_add;
    logic               r1_quad, r1_lin;
    logic [1:0]         r1_kind0;
    logic signed [W:0]  r1_nb;    // -b
    logic signed [W:0]  r1_nc;    // -c
    logic               r1_aneg, r1_bneg;
    logic [MW-1:0]      r1_ma, r1_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_adv) r1_v <= w_in_fire;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_p    <= w_mb * w_mb;
            r1_q    <= w_ma * w_mc;
            r1_add  <= (w_a[W-1] != w_c[W-1]) && (w_c != '0);
            r1_quad <= !is_small(w_ma, r_czl);
            r1_lin  <= !is_small(w_mb, r_czl);
            r1_kind0 <= is_small(w_mc, r_czl) ? KIND_INFINITE : KIND_NONE;
            r1_nb   <= -(W+1)'(w_b);
            r1_nc   <= -(W+1)'(w_c);
            r1_aneg <= w_a[W-1];
            r1_bneg <= w_b[W-1];
            r1_ma   <= w_ma;
            r1_mb   <= w_mb;
        end
    end

    // ---- stage 2: discriminant
    logic [DWD-1:0] w_p, w_q4, w_dm;
    logic           w_dneg;
    always_comb begin
        w_p  = DWD'(r1_p);
        w_q4 = DWD'(r1_q) << 2;
        w_dneg = 1'b0;
        if (r1_add) w_dm = w_p + w_q4;
        else if (w_p < w_q4) begin
            w_dm = w_q4 - w_p;
            w_dneg = 1'b1;
        end else w_dm = w_p - w_q4;
        if (w_dm < DWD'(r_dzl)) begin
            w_dm = '0;
            w_dneg = 1'b0;
        end
    end

    // side payload through the sqrt chain
    typedef struct packed {
        logic              v;
        logic [1:0]        kind;
        logic              quad;
        logic              dneg;
        logic              lin;
        logic signed [W:0] nb;
        logic signed [W:0] nc;
        logic              aneg;
        logic              bneg;
        logic [MW-1:0]     ma;
        logic [MW-1:0]     mb;
    } t_side;
    localparam int SW = $bits(t_side);

    logic [2*RW+1:0] r2_rem;
    t_side           r2_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side.v <= 1'b0;
        end else if (w_adv) begin
            r2_side.v       <= r1_v;
            r2_rem          <= (2*RW+2)'(w_dm);
            r2_side.kind    <= r1_kind0;
            r2_side.quad    <= r1_quad;
            r2_side.dneg    <= w_dneg;
            r2_side.lin     <= r1_lin;
            r2_side.nb      <= r1_nb;
            r2_side.nc      <= r1_nc;
            r2_side.aneg    <= r1_aneg;
            r2_side.bneg    <= r1_bneg;
            r2_side.ma      <= r1_ma;
            r2_side.mb      <= r1_mb;
        end
    end

    // ---- square root chain, one cell per bit from the top
    logic [RW-1:0]   w_sr   [0:RW];
    logic [2*RW+1:0] w_srem [0:RW];
    logic [SW-1:0]   w_ss   [0:RW];
    assign w_sr[0]   = '0;
    assign w_srem[0] = r2_rem;
    assign w_ss[0]   = r2_side;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        qes_sqrt_cell #(.RW(RW), .K(RW - 1 - g), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_root  (w_sr[g]),
            .i_rem   (w_srem[g]),
            .i_side  (w_ss[g]),
            .o_root  (w_sr[g+1]),
            .o_rem   (w_srem[g+1]),
            .o_side  (w_ss[g+1])
        );
    end

    // ---- stage 3: numerators and divisor
    t_side w_s3;
    logic signed [W+2:0] w_s, w_n1, w_n2;
    logic [DV-1:0]  w_div;
    logic [NW-1:0]  w_num1, w_num2;
    logic           w_neg1, w_neg2;
    logic [1:0]     w_kind;
    logic           w_use2;
    always_comb begin
        w_s3  = t_side'(w_ss[RW]);
        w_s   = (W+3)'(w_sr[RW]);
        w_n1  = (W+3)'(w_s3.nb) - w_s;
        w_n2  = (W+3)'(w_s3.nb) + w_s;
        w_kind = w_s3.kind;
        w_use2 = 1'b0;
        if (w_s3.quad) begin
            w_div  = DV'(w_s3.ma) << 1;
            w_neg1 = w_n1[W+2] != w_s3.aneg;
            w_neg2 = w_n2[W+2] != w_s3.aneg;
            w_kind = w_s3.dneg ? KIND_NONE : KIND_TWO;
            w_use2 = !w_s3.dneg;
        end else begin
            w_div  = DV'(w_s3.mb);
            w_n1   = (W+3)'(w_s3.nc);
            w_neg1 = w_n1[W+2] != w_s3.bneg;
            w_neg2 = 1'b0;
            if (w_s3.lin) w_kind = KIND_ONE;
        end
        if (w_div == '0) w_div = DV'(1);
        w_num1 = NW'(w_n1[W+2] ? -w_n1 : w_n1) << FRAC_BITS;
        w_num2 = NW'(w_n2[W+2] ? -w_n2 : w_n2) << FRAC_BITS;
    end

    typedef struct packed {
        logic       v;
        logic [1:0] kind;
        logic       use2;
        logic       neg1;
        logic       neg2;
    } t_dside;
    localparam int DSW = $bits(t_dside);

    logic [NW-1:0]  r3_num1, r3_num2;
    logic [DV-1:0]  r3_div;
    t_dside         r3_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side.v <= 1'b0;
        end else if (w_adv) begin
            r3_side.v <= w_s3.v;
            r3_num1 <= w_num1;
            r3_num2 <= w_num2;
            r3_div  <= w_div;
            r3_side.kind <= w_kind;
            r3_side.use2 <= w_use2;
            r3_side.neg1 <= w_neg1;
            r3_side.neg2 <= w_neg2;
        end
    end

    // ---- divider chain, one cell per quotient bit
    logic [NW-1:0]  w_dn1 [0:NW];
    logic [NW-1:0]  w_dn2 [0:NW];
    logic [DV:0]    w_dr1 [0:NW];
    logic [DV:0]    w_dr2 [0:NW];
    logic [DV-1:0]  w_dd  [0:NW];
    logic [DSW-1:0] w_ds  [0:NW];
    assign w_dn1[0] = r3_num1;
    assign w_dn2[0] = r3_num2;
    assign w_dr1[0] = '0;
    assign w_dr2[0] = '0;
    assign w_dd[0]  = r3_div;
    assign w_ds[0]  = r3_side;

    for (genvar g = 0; g < NW; g++) begin : g_div
        qes_div_cell #(.NW(NW), .DW(DV), .SW(DSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_num1  (w_dn1[g]),
            .i_num2  (w_dn2[g]),
            .i_rem1  (w_dr1[g]),
            .i_rem2  (w_dr2[g]),
            .i_div   (w_dd[g]),
            .i_side  (w_ds[g]),
            .o_num1  (w_dn1[g+1]),
            .o_num2  (w_dn2[g+1]),
            .o_rem1  (w_dr1[g+1]),
            .o_rem2  (w_dr2[g+1]),
            .o_div   (w_dd[g+1]),
            .o_side  (w_ds[g+1])
        );
    end

    // ---- saturation and output register
    t_dside w_fs;
    logic [W-1:0] w_r1, w_r2;
    logic         w_o1, w_o2;
    logic [1:0]   w_fkind;

    function automatic logic [W:0] sat(input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0] lim;
        logic [W-1:0]  m;
        logic          o;
        lim = neg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
        if (q > lim) begin
            m = lim[W-1:0];
            o = 1'b1;
        end else begin
            m = q[W-1:0];
            o = 1'b0;
        end
        sat = {o, neg ? -m : m};
    endfunction

    always_comb begin
        w_fs    = t_dside'(w_ds[NW]);
        w_fkind = w_fs.kind;
        {w_o1, w_r1} = sat(w_dn1[NW], w_fs.neg1);
        {w_o2, w_r2} = sat(w_dn2[NW], w_fs.neg2);
        if (w_fkind == KIND_NONE || w_fkind == KIND_INFINITE) begin
            w_r1 = '0;
            w_o1 = 1'b0;
        end
        if (!w_fs.use2) begin
            w_r2 = '0;
            w_o2 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (w_adv) r_out_v <= w_fs.v;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            out_ch.data.root_kind   <= t_root_kind'(w_fkind);
            out_ch.data.root_first  <= w_r1;
            out_ch.data.root_second <= w_r2;
            out_ch.data.overflow    <= w_o1 | w_o2;
        end
    end
    assign out_ch.valid = r_out_v;
endmodule

>>> design/qes_sqrt_cell.sv
// qes_sqrt_cell: one cell of the square root chain, decides one root bit
// and hands the partial root, remainder and a side payload to the next cell
// depends on nothing

module qes_sqrt_cell #(
    parameter int RW = 64,
    parameter int K  = 0,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [RW-1:0]         i_root,
    input  logic [2*RW+1:0]       i_rem,
    input  logic [SW-1:0]         i_side,
    output logic [RW-1:0]         o_root,
    output logic [2*RW+1:0]       o_rem,
    output logic [SW-1:0]         o_side
);
    logic [2*RW+1:0] w_trial;
    logic [RW-1:0]   r_root;
    logic [2*RW+1:0] r_rem;
    logic [SW-1:0]   r_side;

    // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
    always_comb begin
        w_trial = ((2*RW+2)'(i_root) << (K + 1)) | ((2*RW+2)'(1) << (2 * K));
    end

    // side payload carries the valid bit, so it is cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_rem >= w_trial) begin
                r_rem  <= i_rem - w_trial;
                r_root <= i_root | (RW'(1) << K);
            end else begin
                r_rem  <= i_rem;
                r_root <= i_root;
            end
        end
    end

    assign o_root = r_root;
    assign o_rem  = r_rem;
    assign o_side = r_side;
endmodule

>>> design/qes_div_cell.sv
// qes_div_cell: one restoring division cell, shifts in one numerator bit
// and yields one quotient bit for two dividers sharing a divisor
// depends on nothing

module qes_div_cell #(
    parameter int NW = 80,
    parameter int DW = 50,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [NW-1:0] i_num1,
    input  logic [NW-1:0] i_num2,
    input  logic [DW:0]   i_rem1,
    input  logic [DW:0]   i_rem2,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic [NW-1:0] o_num1,
    output logic [NW-1:0] o_num2,
    output logic [DW:0]   o_rem1,
    output logic [DW:0]   o_rem2,
    output logic [DW-1:0] o_div,
    output logic [SW-1:0] o_side
);
    logic [DW+1:0] w_t1, w_t2;
    logic [NW-1:0] r_num1, r_num2;
    logic [DW:0]   r_rem1, r_rem2;
    logic [DW-1:0] r_div;
    logic [SW-1:0] r_side;

    always_comb begin
        w_t1 = {i_rem1, i_num1[NW-1]};
        w_t2 = {i_rem2, i_num2[NW-1]};
    end

    // side payload carries the valid bit, so it is cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    // numerator register fills with quotient bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= i_div;
            if (w_t1 >= (DW+2)'(i_div)) begin
                r_rem1 <= (DW+1)'(w_t1 - (DW+2)'(i_div));
                r_num1 <= {i_num1[NW-2:0], 1'b1};
            end else begin
                r_rem1 <= w_t1[DW:0];
                r_num1 <= {i_num1[NW-2:0], 1'b0};
            end
            if (w_t2 >= (DW+2)'(i_div)) begin
                r_rem2 <= (DW+1)'(w_t2 - (DW+2)'(i_div));
                r_num2 <= {i_num2[NW-2:0], 1'b1};
            end else begin
                r_rem2 <= w_t2[DW:0];
                r_num2 <= {i_num2[NW-2:0], 1'b0};
            end
        end
    end

    assign o_num1 = r_num1;
    assign o_num2 = r_num2;
    assign o_rem1 = r_rem1;
    assign o_rem2 = r_rem2;
    assign o_div  = r_div;
    assign o_side = r_side;
endmodule

>>> tb/sv/qes_tb_types.sv
// qes_tb_types: payload structs for the coefficient and root channels of the testbench
// depends on qes_pkg

package qes_tb_types;
    import qes_pkg::*;

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } t_coefs;

    typedef struct packed {
        t_root_kind         root_kind;
        logic signed [31:0] root_first;
        logic signed [31:0] root_second;
        logic               overflow;
    } t_roots;
endpackage

>>> tb/sv/quadratic_equation_solver_tb.sv
// quadratic_equation_solver_tb: random and directed check of the root classifier
// depends on qes_pkg, qes_if, qes_tb_types and the solver rtl

module quadratic_equation_solver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qes_pkg::*;
    import qes_tb_types::*;

    localparam int Latency = 4 + 34 + 50;
    localparam int CycleLimit = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CfgAddrWidth-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    qes_if #(.T(t_coefs)) coef_if ();
    qes_if #(.T(t_roots)) root_if ();

    quadratic_equation_solver u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (coef_if),
        .out_ch  (root_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    t_coefs pending_coefs[$];
    t_roots expected_roots[$];
    logic [15:0] coef_limit = 16'd1;
    logic [31:0] disc_limit = 32'd4295;
    bit     calm = 1'b0;
    int     mismatches = 0;
    int     roots_seen = 0;
    int     items_sent = 0;
    int     overflows_seen = 0;
    longint cycles = 0;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit is_tiny(input logic [63:0] m);
        return m == 0 || m < {48'd0, coef_limit};
    endfunction

    // |num| * 2^16 / div, truncated, then signed and clamped to 32 bits
    function automatic logic [31:0] scaled_quot(input logic [63:0] num, input bit neg,
                                                input logic [63:0] div, inout bit ovf);
        logic [127:0] q;
        logic [127:0] lim;
        logic [31:0]  m;
        q = ({64'd0, num} << 16) / {64'd0, div};
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            m = lim[31:0];
            ovf = 1'b1;
        end else begin
            m = q[31:0];
        end
        return neg ? -m : m;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int k = 40; k >= 0; k--) begin
            t = r | (128'd1 << k);
            if (!(v < t * t)) r = t;
        end
        return r[63:0];
    endfunction

    function automatic t_roots solve_roots(input t_coefs cf);
        t_roots res;
        logic signed [63:0] a, b, c, s, n1, n2, n;
        logic [127:0] ma, mb, mc, p, q, dm;
        bit dneg, ovf;
        a = cf.coef_a; b = cf.coef_b; c = cf.coef_c;
        ma = mag64(a); mb = mag64(b); mc = mag64(c);
        res = '0;
        res.root_kind = KIND_NONE;
        ovf = 1'b0;
        dneg = 1'b0;
        if (!is_tiny(ma[63:0])) begin
            p = mb * mb;
            q = (ma * mc) << 2;
            if (((a < 0) != (c < 0)) && c != 0) begin
                dm = p + q;
            end else if (p < q) begin
                dm = q - p;
                dneg = 1'b1;
            end else begin
                dm = p - q;
            end
            if (dm < {96'd0, disc_limit}) begin
                dm = 0;
                dneg = 1'b0;
            end
            if (!dneg) begin
                s = floor_sqrt(dm);
                n1 = -b - s;
                n2 = -b + s;
                res.root_kind = KIND_TWO;
                res.root_first = scaled_quot(mag64(n1), (n1 < 0) != (a < 0), ma[63:0] << 1, ovf);
                res.root_second = scaled_quot(mag64(n2), (n2 < 0) != (a < 0), ma[63:0] << 1, ovf);
            end
        end else if (!is_tiny(mb[63:0])) begin
            n = -c;
            res.root_kind = KIND_ONE;
            res.root_first = scaled_quot(mag64(n), (n < 0) != (b < 0), mb[63:0], ovf);
        end else if (is_tiny(mc[63:0])) begin
            res.root_kind = KIND_INFINITE;
        end
        res.overflow = ovf;
        return res;
    endfunction

    // driver: offers queued items with random gaps
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_if.valid <= 1'b0;
        end else begin
            if (coef_if.valid && coef_if.ready) begin
                expected_roots.push_back(solve_roots(coef_if.data));
                items_sent++;
            end
            if (!coef_if.valid || coef_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    coef_if.valid <= 1'b0;
                end else if (pending_coefs.size() > 0) begin
                    coef_if.valid <= 1'b1;
                    coef_if.data <= pending_coefs.pop_front();
                    if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 6);
                end else begin
                    coef_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure plus one long hold-off
    int  stall_left = 0;
    bit  long_hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_roots want;
        if (!i_rst_n) begin
            root_if.ready <= 1'b0;
        end else begin
            if (root_if.valid && root_if.ready) begin
                roots_seen++;
                if (root_if.data.overflow) overflows_seen++;
                if (expected_roots.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item %p", root_if.data);
                end else begin
                    want = expected_roots.pop_front();
                    if (want.root_kind !== root_if.data.root_kind
                        || want.root_first !== root_if.data.root_first
                        || want.root_second !== root_if.data.root_second
                        || want.overflow !== root_if.data.overflow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, root_if.data);
                    end
                end
            end
            // early in the first random phase, while plenty of items are still queued
            if (!long_hold_done && roots_seen == 30) begin
                long_hold_done = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                root_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6);
                root_if.ready <= 1'b0;
            end else begin
                root_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic cfg_write(input t_reg_addr addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_COEF_ZERO_LIMIT) coef_limit = value[15:0];
        else disc_limit = value;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_coefs.size() > 0 || coef_if.valid || expected_roots.size() > 0)
            @(negedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
    endtask

    task automatic queue_item(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        t_coefs cf;
        cf.coef_a = a; cf.coef_b = b; cf.coef_c = c;
        pending_coefs.push_back(cf);
    endtask

    function automatic logic [31:0] pick_coef();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0, 1: v = $urandom();
            2: v = $urandom_range(0, 1 << 20) - (1 << 19);
            3: v = 0;
            4: v = (($urandom_range(0, 1)) ? -1 : 1) * (coef_limit + $urandom_range(0, 2) - 1);
            5: v = $signed($urandom_range(0, 64) - 32) <<< 16;
            6: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: v = $urandom_range(0, 1 << 26) - (1 << 25);
        endcase
        return v;
    endfunction

    task automatic random_phase(input int count);
        logic signed [31:0] r1, r2, k;
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                // integer roots r1, r2 with scale k: k*x^2 - k*(r1+r2)*x + k*r1*r2
                r1 = $urandom_range(0, 16) - 8;
                r2 = $urandom_range(0, 16) - 8;
                k = $urandom_range(1, 4);
                queue_item(k <<< 16, (-k * (r1 + r2)) <<< 16, (k * r1 * r2) <<< 16);
            end else begin
                queue_item(pick_coef(), pick_coef(), pick_coef());
            end
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // directed: default limits
        @(negedge i_clk);
        queue_item(0, 0, 0);                                  // infinitely many
        queue_item(0, 0, 32'h0001_0000);                      // none
        queue_item(0, 32'h0001_0000, 32'hfffd_0000);          // linear root 3
        queue_item(0, 1, 32'h7fff_ffff);                      // linear overflow
        queue_item(0, 32'h8000_0000, 32'h8000_0000);
        queue_item(32'h0001_0000, 0, 32'h0001_0000);          // negative discriminant
        queue_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000); // double root
        queue_item(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000); // roots 1 and 2
        queue_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        queue_item(1, 32'h7fff_ffff, 0);                      // quadratic overflow
        queue_item(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        queue_item(32'h0001_0000, 1, 0);                      // tiny discriminant
        queue_item(32'h0001_0000, 0, 0);
        queue_item(32'h0001_0000, 0, 32'hffff_0000);          // roots -1 and 1
        drain();

        // zero limits: only exact zero counts as zero
        cfg_write(REG_COEF_ZERO_LIMIT, 32'd0);
        cfg_write(REG_DISC_ZERO_LIMIT, 32'd0);
        @(negedge i_clk);
        queue_item(1, 0, 0);
        queue_item(1, 2, 1);
        queue_item(0, 1, 1);
        queue_item(0, 0, 1);
        queue_item(32'h0001_0000, 1, 0);
        drain();
        random_phase(100);

        // largest limits
        cfg_write(REG_COEF_ZERO_LIMIT, 32'd65535);
        cfg_write(REG_DISC_ZERO_LIMIT, 32'hffff_ffff);
        @(negedge i_clk);
        queue_item(32'h0000_ffff, 32'h0001_0000, 32'h0000_ffff);
        queue_item(32'hffff_0001, 32'h0000_ffff, 32'h0001_0000);
        queue_item(32'h0001_0000, 0, 32'hffff_ffff);
        drain();
        random_phase(100);

        cfg_write(REG_COEF_ZERO_LIMIT, $urandom_range(0, 65535));
        cfg_write(REG_DISC_ZERO_LIMIT, $urandom());
        random_phase(100);

        cfg_write(REG_COEF_ZERO_LIMIT, 32'd1);
        cfg_write(REG_DISC_ZERO_LIMIT, 32'd4295);
        random_phase(150);

        calm <= 1'b1;
        random_phase(60);

        $display("covered %0d items, %0d results, %0d saturated, limits swept from zero to max",
                 items_sent, roots_seen, overflows_seen);
        if (mismatches == 0 && expected_roots.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("mismatches: %0d, left over: %0d", mismatches, expected_roots.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> quadratic_equation_solver.f
design/qes_pkg.sv
design/qes_if.sv
design/qes_sqrt_cell.sv
design/qes_div_cell.sv
design/quadratic_equation_solver.sv
tb/sv/qes_tb_types.sv
tb/sv/quadratic_equation_solver_tb.sv
